// ----- sv/assert_macros.svh -----
// assertion helpers used by the srfi_checker module
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SRFI_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SRFI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRFI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/srfi_pkg.sv -----
// ----------------------------------------------------------------------------
// srfi_pkg
// types, codes and constants of the sector range fault injector
// ----------------------------------------------------------------------------
package srfi_pkg;

    // sector address width of every range and access
    localparam int SECTOR_BITS = 48;
    // default number of ranges held by the active and staging tables
    localparam int TABLE_ENTRIES_DEF = 16;

    // delays must be multiples of this step
    localparam int DELAY_STEP = 100;
    // reciprocal of the delay step, exact for 15-bit delays
    localparam int DELAY_RECIP = 5243;
    localparam int DELAY_SHIFT = 19;
    localparam int DELAY_Q_W = 9;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_COMMIT = 2'd2,
        KIND_CHECK  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_BAD     = 3'd1,
        STS_OVERLAP = 3'd2,
        STS_FULL    = 3'd3,
        STS_REFUSED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_FAIL  = 2'd1,
        ACT_DELAY = 2'd2
    } action_t;

    typedef enum logic [0:0] {
        CFG_GLOBAL_ERROR = 1'b0,
        CFG_GLOBAL_DELAY = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_VALIDATE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t                   kind;
        logic [SECTOR_BITS-1:0]  range_start;
        logic [SECTOR_BITS-1:0]  range_end;
        logic signed [31:0]      range_error;
        logic signed [15:0]      range_delay_ms;
        logic [SECTOR_BITS-1:0]  access_sector;
        logic                    already_delayed;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        action_t            action;
        logic signed [31:0] result_error;
        logic [15:0]        result_delay_ms;
    } out_item_t;

    // one stored range
    typedef struct packed {
        logic [SECTOR_BITS-1:0] ent_start;
        logic [SECTOR_BITS-1:0] ent_end;
        logic [31:0]            ent_error;
        logic [15:0]            ent_delay;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic calc_q;
        logic eval;
        logic scan_start;
        logic scan_run;
        logic apply;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  global_set;
        logic  bad;
        logic  scan_done;
    } stat_t;

endpackage

// ----- sv/srfi_ctrl.sv -----
// ----------------------------------------------------------------------------
// srfi_ctrl
// sequencer for one item: decode, validate, table scan, result hand-off
// ----------------------------------------------------------------------------
module srfi_ctrl
    import srfi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.kind)
                    KIND_ADD:
                    begin
                        cmd.calc_q = 1'b1;
                        state_next = ST_VALIDATE;
                    end
                    KIND_CHECK:
                    begin
                        if (stat.global_set)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_VALIDATE:
            begin
                cmd.eval = 1'b1;
                if (stat.bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/srfi_dpath.sv -----
// ----------------------------------------------------------------------------
// srfi_dpath
// item register, field checks, double-banked range memory with scan unit,
// batch bookkeeping and result register
// ----------------------------------------------------------------------------
module srfi_dpath
    import srfi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  in_item_t    in_data,
    input  logic        cfg_valid,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data,
    output out_item_t   out_data
);

    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int MEM_DEPTH = 2 * (2 ** IDX_W);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam int PROD_W    = 15 + 13;

    // range memory: two banks, one active and one staging
    entry_t mem [MEM_DEPTH];

    in_item_t               item_reg;
    logic [DELAY_Q_W-1:0]   q_reg;
    logic                   bad_reg;
    logic [31:0]            gerr_reg;
    logic [15:0]            gdly_reg;

    logic                   act_bank_reg, act_bank_next;
    logic [CNT_W-1:0]       act_cnt_reg, act_cnt_next;
    logic [CNT_W-1:0]       stg_cnt_reg, stg_cnt_next;
    logic                   failed_reg, failed_next;

    logic [CNT_W-1:0]       ptr_reg;
    logic                   rd_vld_reg;
    entry_t                 rd_data_reg;
    logic                   hit_reg;
    logic [31:0]            cap_err_reg;
    logic [15:0]            cap_dly_reg;

    out_item_t              out_reg, out_next;
    logic                   wr_en;
    logic [IDX_W:0]         wr_addr;
    entry_t                 wr_entry;

    logic                   is_add;
    logic                   scan_bank;
    logic [CNT_W-1:0]       scan_limit;
    logic                   issue;
    logic                   match;
    logic                   global_set;
    logic [PROD_W-1:0]      prod;
    logic                   bad_now;

    // item register, delay quotient and field-check flag
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_data;
        end
        if (cmd.calc_q)
        begin
            q_reg <= DELAY_Q_W'(prod >> DELAY_SHIFT);
        end
        if (cmd.eval)
        begin
            bad_reg <= bad_now;
        end
    end

    assign prod = PROD_W'(item_reg.range_delay_ms[14:0]) * PROD_W'(DELAY_RECIP);

    // field checks of an add
    always_comb
    begin
        bad_now = (item_reg.range_start >= item_reg.range_end)
               || (!item_reg.range_error[31] && (item_reg.range_error != 32'sd0))
               || item_reg.range_delay_ms[15]
               || (16'(q_reg * DELAY_STEP) != 16'(item_reg.range_delay_ms))
               || ((item_reg.range_error == 32'sd0) && (item_reg.range_delay_ms == 16'sd0));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gerr_reg <= '0;
            gdly_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GLOBAL_ERROR: gerr_reg <= cfg_data;
                CFG_GLOBAL_DELAY: gdly_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign global_set = (gerr_reg != 32'd0) || (gdly_reg != 16'd0);

    // scan source: staging bank for adds, active bank for checks
    assign is_add     = (item_reg.kind == KIND_ADD);
    assign scan_bank  = is_add ? !act_bank_reg : act_bank_reg;
    assign scan_limit = is_add ? stg_cnt_reg : act_cnt_reg;
    assign issue      = cmd.scan_run && !hit_reg && (ptr_reg < scan_limit);

    // overlap for adds, containment for checks
    always_comb
    begin
        if (is_add)
        begin
            match = (item_reg.range_end > rd_data_reg.ent_start)
                 && (rd_data_reg.ent_end > item_reg.range_start);
        end
        else
        begin
            match = (rd_data_reg.ent_start <= item_reg.access_sector)
                 && (item_reg.access_sector < rd_data_reg.ent_end);
        end
    end

    // scan unit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            rd_vld_reg <= issue;
            if (issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (rd_vld_reg && match)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // first matching range found by a scan
    always_ff @(posedge clk)
    begin
        if (cmd.scan_run && rd_vld_reg && !hit_reg && match)
        begin
            cap_err_reg <= rd_data_reg.ent_error;
            cap_dly_reg <= rd_data_reg.ent_delay;
        end
    end

    // range memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{scan_bank, ptr_reg[IDX_W-1:0]}];
        end
    end

    assign wr_addr  = {!act_bank_reg, stg_cnt_reg[IDX_W-1:0]};
    assign wr_entry = '{ent_start: item_reg.range_start,
                        ent_end:   item_reg.range_end,
                        ent_error: item_reg.range_error,
                        ent_delay: item_reg.range_delay_ms};

    // batch bookkeeping and result
    always_comb
    begin
        act_bank_next = act_bank_reg;
        act_cnt_next  = act_cnt_reg;
        stg_cnt_next  = stg_cnt_reg;
        failed_next   = failed_reg;
        wr_en         = 1'b0;
        out_next      = '{status: STS_OK, action: ACT_PASS,
                          result_error: 32'sd0, result_delay_ms: 16'd0};
        case (item_reg.kind)
            KIND_BEGIN:
            begin
                stg_cnt_next = '0;
                failed_next  = 1'b0;
            end
            KIND_ADD:
            begin
                if (bad_reg)
                begin
                    out_next.status = STS_BAD;
                    failed_next     = 1'b1;
                end
                else if (hit_reg)
                begin
                    out_next.status = STS_OVERLAP;
                    failed_next     = 1'b1;
                end
                else if (stg_cnt_reg >= FULL_CNT)
                begin
                    out_next.status = STS_FULL;
                    failed_next     = 1'b1;
                end
                else
                begin
                    wr_en        = cmd.apply;
                    stg_cnt_next = stg_cnt_reg + 1'b1;
                end
            end
            KIND_COMMIT:
            begin
                if (failed_reg)
                begin
                    out_next.status = STS_REFUSED;
                end
                else
                begin
                    act_bank_next = !act_bank_reg;
                    act_cnt_next  = stg_cnt_reg;
                end
                stg_cnt_next = '0;
                failed_next  = 1'b0;
            end
            KIND_CHECK:
            begin
                if (global_set)
                begin
                    out_next.result_error    = gerr_reg;
                    out_next.result_delay_ms = gdly_reg;
                end
                else if (hit_reg)
                begin
                    out_next.result_error    = cap_err_reg;
                    out_next.result_delay_ms = cap_dly_reg;
                end
                if (out_next.result_error != 32'sd0)
                begin
                    out_next.action = ACT_FAIL;
                end
                else if ((out_next.result_delay_ms != 16'd0) && !item_reg.already_delayed)
                begin
                    out_next.action = ACT_DELAY;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_bank_reg <= 1'b0;
            act_cnt_reg  <= '0;
            stg_cnt_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        else if (cmd.apply)
        begin
            act_bank_reg <= act_bank_next;
            act_cnt_reg  <= act_cnt_next;
            stg_cnt_reg  <= stg_cnt_next;
            failed_reg   <= failed_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data        = out_reg;
    assign stat.kind       = item_reg.kind;
    assign stat.global_set = global_set;
    assign stat.bad        = bad_now;
    assign stat.scan_done  = hit_reg || ((ptr_reg >= scan_limit) && !rd_vld_reg);

endmodule

// ----- sv/sector_range_fault_injector_core.sv -----
// steps: an item is latched and decoded; begin and commit then give their result; a check
// with a global fault set goes straight to its result, else scans the active ranges; an
// add has its fields checked and gives its result on bad fields, else scans the staged ranges
// flow: one item at a time, the next taken the cycle after the result is loaded; spacing
// is set by the scan over the range memory's single read port and by output stalls
// reset: asynchronous, active low; both tables empty, globals zero, no memory clearing
module sector_range_fault_injector_core
    import srfi_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    srfi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // tables and result
    srfi_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

// ----- sv/srfi_checker.sv -----
// ----------------------------------------------------------------------------
// srfi_checker
// port-level checks of the fault injector core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srfi_checker
    import srfi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting result holds
    `SRFI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // one item at a time: busy right after an accept
    `SRFI_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while busy")

    // batch results that are not OK carry no access decision
    `SRFI_ASSERT_IMP(a_batch_clean, out_valid && (out_data.status != STS_OK), (out_data.action == ACT_PASS) && (out_data.result_error == 32'sd0) && (out_data.result_delay_ms == 16'd0), "non-check result carries an action")

    // fail needs an error, delay needs a delay and no error
    `SRFI_ASSERT(a_action_consistent, !out_valid || ((out_data.action != ACT_FAIL || out_data.result_error != 32'sd0) && (out_data.action != ACT_DELAY || (out_data.result_delay_ms != 16'd0 && out_data.result_error == 32'sd0))), "action disagrees with resolved values")

endmodule

bind sector_range_fault_injector_core srfi_checker u_srfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/sector_range_fault_injector_core_test.sv -----
// ----------------------------------------------------------------------------
// sector_range_fault_injector_core_test
// self-checking bench for the sector range fault injector: a short scripted
// run over the corner cases, then batches of random ranges and accesses under
// several global error and delay settings, scored by pinned rows or a model
// ----------------------------------------------------------------------------
module sector_range_fault_injector_core_test;
    import srfi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int TABLE_N     = 16;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [47:0] SECTOR_MAX = 48'hFFFF_FFFF_FFFF;

    // one range as held by the model tables
    typedef struct packed {
        logic [47:0] lo;
        logic [47:0] hi;
        logic [31:0] err;
        logic [15:0] dly;
    } range_rec_t;

    // one scripted item, with its outcome written out where it is obvious
    typedef struct packed {
        in_item_t  item;
        logic      pinned;
        out_item_t want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;

    // outcome override travelling alongside the item being offered
    logic        item_pinned;
    out_item_t   pinned_outcome;

    // model state
    range_rec_t         live_tab [TABLE_N];
    range_rec_t         stage_tab [TABLE_N];
    int                 stage_fill;
    bit                 stage_bad;
    logic signed [31:0] glob_err;
    logic [15:0]        glob_dly;

    out_item_t  pending_outcomes [$];
    in_item_t   plan [$];
    range_rec_t batch_ranges [$];
    step_row_t  script [$];
    int         failures;
    int         results_seen;
    int         quiet_cycles;
    bit         send_steady;

    sector_range_fault_injector_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // model of the injector
    // ------------------------------------------------------------------

    function automatic void clear_stage();
        int k;
        for (k = 0; k < TABLE_N; k++)
        begin
            stage_tab[k] = '0;
        end
        stage_fill = 0;
        stage_bad  = 1'b0;
    endfunction

    function automatic out_item_t injector_outcome(in_item_t it);
        out_item_t          o;
        int                 er;
        int                 dl;
        int                 k;
        bit                 clash;
        bit                 found;
        logic signed [31:0] r_err;
        logic [15:0]        r_dly;
        o        = '0;
        o.status = STS_OK;
        o.action = ACT_PASS;
        case (it.kind)
            KIND_BEGIN:
            begin
                clear_stage();
            end
            KIND_ADD:
            begin
                er = $signed(it.range_error);
                dl = $signed(it.range_delay_ms);
                // field checks come before the overlap and capacity checks
                if (it.range_start >= it.range_end || er > 0 || dl < 0 ||
                    (dl % DELAY_STEP) != 0 || (er == 0 && dl == 0))
                begin
                    stage_bad = 1'b1;
                    o.status  = STS_BAD;
                end
                else
                begin
                    clash = 1'b0;
                    for (k = 0; k < stage_fill; k++)
                    begin
                        if (it.range_end > stage_tab[k].lo && stage_tab[k].hi > it.range_start)
                        begin
                            clash = 1'b1;
                        end
                    end
                    if (clash)
                    begin
                        stage_bad = 1'b1;
                        o.status  = STS_OVERLAP;
                    end
                    else if (stage_fill >= TABLE_N)
                    begin
                        stage_bad = 1'b1;
                        o.status  = STS_FULL;
                    end
                    else
                    begin
                        stage_tab[stage_fill] = '{it.range_start, it.range_end,
                                                  it.range_error, it.range_delay_ms};
                        stage_fill++;
                    end
                end
            end
            KIND_COMMIT:
            begin
                // all or nothing: a single rejected add refuses the batch
                if (stage_bad)
                begin
                    o.status = STS_REFUSED;
                end
                else
                begin
                    for (k = 0; k < TABLE_N; k++)
                    begin
                        live_tab[k] = stage_tab[k];
                    end
                end
                clear_stage();
            end
            default:
            begin
                r_err = glob_err;
                r_dly = glob_dly;
                // globals win, else the first live range holding the sector
                if (r_err == 0 && r_dly == 0)
                begin
                    found = 1'b0;
                    for (k = 0; k < TABLE_N; k++)
                    begin
                        if (!found && live_tab[k].lo <= it.access_sector &&
                            live_tab[k].hi > it.access_sector)
                        begin
                            found = 1'b1;
                            r_err = live_tab[k].err;
                            r_dly = live_tab[k].dly;
                        end
                    end
                end
                if (r_err != 0)
                begin
                    o.action = ACT_FAIL;
                end
                else if (r_dly != 0 && !it.already_delayed)
                begin
                    o.action = ACT_DELAY;
                end
                o.result_error    = r_err;
                o.result_delay_ms = r_dly;
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [47:0] rand_sector();
        logic [47:0] v;
        v = 48'({$urandom(), $urandom()});
        return v;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.kind            = kind_t'($urandom_range(0, 3));
        it.range_start     = rand_sector();
        it.range_end       = rand_sector();
        it.range_error     = $urandom();
        it.range_delay_ms  = 16'($urandom());
        it.access_sector   = rand_sector();
        it.already_delayed = 1'($urandom());
        return it;
    endfunction

    function automatic in_item_t mk_item(kind_t k, logic [47:0] s, logic [47:0] e,
                                         logic [31:0] er, logic [15:0] dl,
                                         logic [47:0] sec, logic ad);
        in_item_t it;
        it = '{k, s, e, er, dl, sec, ad};
        return it;
    endfunction

    function automatic out_item_t mk_out(status_t st, action_t ac, logic [31:0] er,
                                         logic [15:0] dl);
        out_item_t o;
        o = '{st, ac, er, dl};
        return o;
    endfunction

    // scripted corner cases, globals at their reset value of zero
    task automatic load_script();
        out_item_t none;
        none = '0;
        // empty tables after reset
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        // each kind of bad field
        script.push_back('{mk_item(KIND_ADD, 5, 5, -1, 0, 0, 0), 1'b1,
                           mk_out(STS_BAD, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 0, 10, 32'h7FFF_FFFF, 0, 0, 0), 1'b1,
                           mk_out(STS_BAD, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 0, 10, 0, 16'h8000, 0, 0), 1'b1,
                           mk_out(STS_BAD, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 0, 10, -1, 16'h7FFF, 0, 0), 1'b1,
                           mk_out(STS_BAD, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 0, 10, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_BAD, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_REFUSED, ACT_PASS, 0, 0)});
        // clean batch, the last range at the top of the sector space
        script.push_back('{mk_item(KIND_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 0, 100, -5, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 100, 200, 0, 300, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, SECTOR_MAX - 1, SECTOR_MAX, 32'h8000_0000,
                                   32700, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        // accesses at and around the range boundaries
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 0, 0), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 99, 0), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 100, 0), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 150, 1), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 200, 0), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, SECTOR_MAX - 1, 1), 1'b0, none});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, SECTOR_MAX, 0), 1'b0, none});
        // overlapping add spoils the batch, live table kept
        script.push_back('{mk_item(KIND_BEGIN, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 10, 20, -2, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_ADD, 15, 16, -3, 0, 0, 0), 1'b1,
                           mk_out(STS_OVERLAP, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_REFUSED, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 12, 0), 1'b0, none});
        // commit of an empty staging table clears the live table
        script.push_back('{mk_item(KIND_COMMIT, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
        script.push_back('{mk_item(KIND_CHECK, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_out(STS_OK, ACT_PASS, 0, 0)});
    endtask

    // one episode: noise, a batch followed by accesses, or accesses alone
    task automatic plan_episode();
        int          pick;
        int          n_adds;
        int          k;
        bit          huge;
        logic [47:0] cursor;
        logic [47:0] lo;
        logic [47:0] hi;
        range_rec_t  rr;
        in_item_t    it;
        pick = $urandom_range(0, 9);
        huge = ($urandom_range(0, 3) == 0);
        if (pick == 0)
        begin
            repeat ($urandom_range(1, 4)) plan.push_back(random_item());
            return;
        end
        if (pick <= 7)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                it      = random_item();
                it.kind = KIND_BEGIN;
                plan.push_back(it);
            end
            // mostly small batches, now and then enough to overflow staging
            n_adds = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
            cursor = huge ? (rand_sector() >> 1) : 48'($urandom_range(0, 500));
            batch_ranges.delete();
            for (k = 0; k < n_adds; k++)
            begin
                it      = random_item();
                it.kind = KIND_ADD;
                lo      = cursor + (huge ? (rand_sector() >> 8) : 48'($urandom_range(0, 40)));
                hi      = lo + 1 + (huge ? (rand_sector() >> 8) : 48'($urandom_range(0, 59)));
                cursor  = hi;
                it.range_start = lo;
                it.range_end   = hi;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        it.range_error    = 0;
                        it.range_delay_ms = 16'(100 * $urandom_range(1, 327));
                    end
                    1:
                    begin
                        it.range_error    = $urandom_range(0, 1) ? {1'b1, 31'($urandom())}
                                                                 : -$urandom_range(1, 200);
                        it.range_delay_ms = 0;
                    end
                    default:
                    begin
                        it.range_error    = -$urandom_range(1, 5000);
                        it.range_delay_ms = 16'(100 * $urandom_range(1, 327));
                    end
                endcase
                // occasional broken add
                if ($urandom_range(0, 11) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0: it.range_end = it.range_start - $urandom_range(0, 3);
                        1: it.range_error = $urandom_range(1, 32'h7FFF_FFFF);
                        2: it.range_delay_ms = 16'(-100 * int'($urandom_range(1, 327)));
                        3: it.range_delay_ms = 16'(100 * $urandom_range(0, 326) +
                                                   $urandom_range(1, 99));
                        4:
                        begin
                            it.range_error    = 0;
                            it.range_delay_ms = 0;
                        end
                        default:
                        begin
                            if (batch_ranges.size() > 0)
                            begin
                                rr = batch_ranges[$urandom_range(0, batch_ranges.size() - 1)];
                                it.range_start = rr.lo;
                                it.range_end   = rr.hi + 1;
                            end
                            else
                            begin
                                it.range_end = it.range_start;
                            end
                        end
                    endcase
                end
                else
                begin
                    batch_ranges.push_back('{lo, hi, it.range_error, it.range_delay_ms});
                end
                plan.push_back(it);
            end
            it      = random_item();
            it.kind = KIND_COMMIT;
            plan.push_back(it);
        end
        // accesses aimed mostly at the ranges of the latest batch
        repeat ($urandom_range(2, 8))
        begin
            it      = random_item();
            it.kind = KIND_CHECK;
            pick    = $urandom_range(0, 5);
            if (batch_ranges.size() > 0 && pick <= 3)
            begin
                rr = batch_ranges[$urandom_range(0, batch_ranges.size() - 1)];
                case (pick)
                    0: it.access_sector = rr.lo - 1;
                    1: it.access_sector = rr.hi - $urandom_range(0, 1);
                    default: it.access_sector = rr.lo + (rand_sector() % (rr.hi - rr.lo));
                endcase
            end
            else if (!huge)
            begin
                it.access_sector = 48'($urandom_range(0, 1500));
            end
            plan.push_back(it);
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic offer_item(in_item_t it, logic pinned, out_item_t want);
        int gap;
        if ($urandom_range(0, 15) == 0)
        begin
            send_steady = !send_steady;
        end
        gap = send_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_data        <= it;
        item_pinned    <= pinned;
        pinned_outcome <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic run_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            if (plan.size() == 0)
            begin
                plan_episode();
            end
            offer_item(plan.pop_front(), 1'b0, '0);
            sent++;
        end
    endtask

    // stop offering and wait for every outstanding outcome
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper bits of the delay write are junk and must be ignored
    task automatic apply_globals(logic [31:0] err, logic [15:0] dly);
        write_reg(CFG_GLOBAL_ERROR, err);
        write_reg(CFG_GLOBAL_DELAY, {16'($urandom()), dly});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall;
        int taken;
        bit steady;
        out_ready = 1'b0;
        taken     = 0;
        steady    = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                steady = !steady;
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // scoreboard: predict on input item, compare on output item
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GLOBAL_ERROR: glob_err = cfg_data;
                    CFG_GLOBAL_DELAY: glob_dly = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want = injector_outcome(in_data);
                if (item_pinned)
                begin
                    want = pinned_outcome;
                end
                pending_outcomes.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                results_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("result %0d arrived with nothing outstanding", results_seen);
                    end
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status || got.action !== want.action ||
                        got.result_error !== want.result_error ||
                        got.result_delay_ms !== want.result_delay_ms)
                    begin
                        failures++;
                        if (failures <= 10)
                        begin
                            $write("result %0d: status %0d/%0d action %0d/%0d ",
                                   results_seen, want.status, got.status, want.action,
                                   got.action);
                            $display("error %0d/%0d delay %0d/%0d (exp/got)",
                                     $signed(want.result_error), $signed(got.result_error),
                                     want.result_delay_ms, got.result_delay_ms);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sector_range_fault_injector_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        int k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_GLOBAL_ERROR;
        cfg_data       = '0;
        item_pinned    = 1'b0;
        pinned_outcome = '0;
        failures       = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        send_steady    = 1'b0;
        glob_err       = '0;
        glob_dly       = '0;
        for (k = 0; k < TABLE_N; k++)
        begin
            live_tab[k] = '0;
        end
        clear_stage();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // scripted corner cases
        load_script();
        for (k = 0; k < script.size(); k++)
        begin
            offer_item(script[k].item, script[k].pinned, script[k].want);
        end

        // random phases, globals changed only while idle
        settle();
        apply_globals(32'h0, 16'h0);
        run_random(300);
        settle();
        apply_globals(32'hFFFF_FFFF, 16'h0);
        run_random(100);
        settle();
        apply_globals(32'h0, 16'd100);
        run_random(150);
        settle();
        apply_globals(32'h7FFF_FFFF, 16'hFFFF);
        run_random(100);
        settle();
        apply_globals(32'h8000_0000, 16'h0);
        run_random(100);
        settle();
        apply_globals(32'h0, 16'h0001);
        run_random(100);
        settle();
        apply_globals(32'h0, 16'h0);
        run_random(350);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending_outcomes.size() == 0)
        begin
            $display("sector_range_fault_injector_core verification clean");
        end
        else
        begin
            $display("sector_range_fault_injector_core verification failed");
        end
        $finish;
    end

endmodule
